[hw/rtl/pthc_pkg.sv]
// shared types and constants for the pth sensor compensation datapath
`timescale 1ns / 1ps

package pthc_pkg;

    localparam int DIV_STEPS = 64;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 31;

    typedef enum logic [2:0] {
        CFG_CAL_TEMP       = 3'd0,
        CFG_CAL_PRESS_A    = 3'd1,
        CFG_CAL_PRESS_B    = 3'd2,
        CFG_CAL_PRESS_NINE = 3'd3,
        CFG_CAL_HUM        = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [19:0] tc;
        logic signed [24:0] tfine;
        logic [16:0]        hum;
        logic               pvalid;
    } t_div_side;

    typedef struct packed {
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den_mag;
        logic             q_neg;
        t_div_side        side;
    } t_div_in;

    typedef struct packed {
        logic [NUM_W-1:0] quot_mag;
        logic             q_neg;
        t_div_side        side;
    } t_div_out;

endpackage

[hw/rtl/pthc_divider.sv]
// pipelined restoring divider, one quotient bit per stage, with side payload
`timescale 1ns / 1ps

module pthc_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  pthc_pkg::t_div_in  i_data,
    output logic               o_vld,
    output pthc_pkg::t_div_out o_data
);

    typedef struct packed {
        logic [pthc_pkg::DEN_W-1:0] rem;
        logic [pthc_pkg::NUM_W-1:0] nq;
    } t_div_acc;

    function automatic t_div_acc div_step(input t_div_acc a,
                                          input logic [pthc_pkg::DEN_W-1:0] den);
        logic [pthc_pkg::DEN_W:0]   rem_sh;
        logic [pthc_pkg::DEN_W+1:0] diff;
        t_div_acc                   res;
        rem_sh  = {a.rem, a.nq[pthc_pkg::NUM_W-1]};
        diff    = {1'b0, rem_sh} - {2'b00, den};
        res.nq  = {a.nq[pthc_pkg::NUM_W-2:0], ~diff[pthc_pkg::DEN_W+1]};
        res.rem = diff[pthc_pkg::DEN_W+1] ? rem_sh[pthc_pkg::DEN_W-1:0]
                                          : diff[pthc_pkg::DEN_W-1:0];
        return res;
    endfunction

    logic [pthc_pkg::DIV_STEPS-1:0] r_vld;
    t_div_acc                       r_acc  [pthc_pkg::DIV_STEPS];
    t_div_acc                       n_acc  [pthc_pkg::DIV_STEPS];
    logic [pthc_pkg::DEN_W-1:0]     r_den  [pthc_pkg::DIV_STEPS];
    logic                           r_neg  [pthc_pkg::DIV_STEPS];
    pthc_pkg::t_div_side            r_side [pthc_pkg::DIV_STEPS];
    t_div_acc                       w_init;

    assign w_init.rem = '0;
    assign w_init.nq  = i_data.num_mag;

    always_comb begin
        n_acc[0] = div_step(w_init, i_data.den_mag);
        for (int k = 1; k < pthc_pkg::DIV_STEPS; k++) begin
            n_acc[k] = div_step(r_acc[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[pthc_pkg::DIV_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0]  <= n_acc[0];
            r_den[0]  <= i_data.den_mag;
            r_neg[0]  <= i_data.q_neg;
            r_side[0] <= i_data.side;
            for (int k = 1; k < pthc_pkg::DIV_STEPS; k++) begin
                r_acc[k]  <= n_acc[k];
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld           = r_vld[pthc_pkg::DIV_STEPS-1];
    assign o_data.quot_mag = r_acc[pthc_pkg::DIV_STEPS-1].nq;
    assign o_data.q_neg    = r_neg[pthc_pkg::DIV_STEPS-1];
    assign o_data.side     = r_side[pthc_pkg::DIV_STEPS-1];

endmodule

[hw/rtl/pth_sensor_compensation.sv]
// top level: pipelined temperature, pressure and humidity compensation
// usage:
//   write the five calibration registers over the cfg channel (index 0..4,
//   data in the low bits) while no transaction is in flight; cfg is always ready
//   each slave transaction carries one raw sample, each master transaction one
//   compensated result; tdata/tuser layouts are listed at the ports
//   path: a sample passes twelve front stages, a 64 stage pressure divider,
//   four back stages and the output register before its result is valid
//   throughput: one sample per cycle while not stalled, back to back, no gaps required
//   stall: an output register plus one skid entry; when the receiver holds
//   tready low the skid fills and the whole pipeline freezes with tready low
//   on the slave side, nothing is dropped or repeated
//   reset: all valid bits clear, calibration registers read zero
//   pressure reads zero with the tuser flag low when its divisor is zero
`timescale 1ns / 1ps

module pth_sensor_compensation (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [55:0]   i_s_axis_tdata,  // raw_temp[19:0] raw_press[39:20] raw_hum[55:40]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [119:0]  o_m_axis_tdata,  // temp_centi[31:0] fine_temp[63:32]
                                           // press_q8[95:64] hum_q10[112:96] zero[119:113]
    output logic          o_m_axis_tuser   // press_valid[0]
);

    localparam int FRONT_STAGES = 12;
    localparam int BACK_STAGES  = 4;
    localparam logic [28:0] HUM_MAX_ACC = 29'd419430400;

    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] tfine;
        logic [31:0]        press;
        logic               pvalid;
        logic [16:0]        hum;
    } t_result;

    // calibration registers
    logic [47:0]        r_cal_temp;
    logic [63:0]        r_cal_pa;
    logic [63:0]        r_cal_pb;
    logic signed [15:0] r_cal_p9;
    logic [63:0]        r_cal_hum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp <= '0;
            r_cal_pa   <= '0;
            r_cal_pb   <= '0;
            r_cal_p9   <= '0;
            r_cal_hum  <= '0;
        end else if (i_cfg_valid) begin
            unique case (pthc_pkg::t_cfg_idx'(i_cfg_index))
                pthc_pkg::CFG_CAL_TEMP:       r_cal_temp <= i_cfg_data[47:0];
                pthc_pkg::CFG_CAL_PRESS_A:    r_cal_pa   <= i_cfg_data;
                pthc_pkg::CFG_CAL_PRESS_B:    r_cal_pb   <= i_cfg_data;
                pthc_pkg::CFG_CAL_PRESS_NINE: r_cal_p9   <= i_cfg_data[15:0];
                pthc_pkg::CFG_CAL_HUM:        r_cal_hum  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // coefficient fields
    logic signed [16:0] w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic signed [16:0] w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8;
    logic signed [8:0]  w_h1, w_h3;
    logic signed [15:0] w_h2;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = $signed({1'b0, r_cal_temp[15:0]});
    assign w_t2 = r_cal_temp[31:16];
    assign w_t3 = r_cal_temp[47:32];
    assign w_p1 = $signed({1'b0, r_cal_pa[15:0]});
    assign w_p2 = r_cal_pa[31:16];
    assign w_p3 = r_cal_pa[47:32];
    assign w_p4 = r_cal_pa[63:48];
    assign w_p5 = r_cal_pb[15:0];
    assign w_p6 = r_cal_pb[31:16];
    assign w_p7 = r_cal_pb[47:32];
    assign w_p8 = r_cal_pb[63:48];
    assign w_h1 = $signed({1'b0, r_cal_hum[7:0]});
    assign w_h2 = r_cal_hum[23:8];
    assign w_h3 = $signed({1'b0, r_cal_hum[31:24]});
    assign w_h4 = r_cal_hum[43:32];
    assign w_h5 = r_cal_hum[55:44];
    assign w_h6 = r_cal_hum[63:56];

    logic w_en;
    logic r_skid_vld;
    logic r_out_vld;

    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    logic [FRONT_STAGES-1:0] r_fvld;
    logic [BACK_STAGES-1:0]  r_bvld;

    // stage 0: capture
    logic [19:0] r_s0_raw_t, r_s0_raw_p;
    logic [15:0] r_s0_raw_h;

    // stage 1
    logic signed [17:0] w1_tdiff;
    logic signed [16:0] w1_d;
    logic signed [33:0] w1_tprod, w1_dd;
    logic signed [22:0] r_s1_ta;
    logic signed [21:0] r_s1_dd12;
    logic [19:0]        r_s1_raw_p;
    logic [15:0]        r_s1_raw_h;

    assign w1_tdiff = $signed({1'b0, r_s0_raw_t[19:3]}) - $signed({1'b0, r_cal_temp[15:0], 1'b0});
    assign w1_d     = $signed({1'b0, r_s0_raw_t[19:4]}) - w_t1;
    assign w1_tprod = w1_tdiff * w_t2;
    assign w1_dd    = w1_d * w1_d;

    // stage 2
    logic signed [37:0] w2_tbp;
    logic signed [24:0] n_s2_tfine;
    logic signed [24:0] r_s2_tfine;
    logic [19:0]        r_s2_raw_p;
    logic [15:0]        r_s2_raw_h;

    assign w2_tbp     = r_s1_dd12 * w_t3;
    assign n_s2_tfine = 25'(r_s1_ta) + 25'($signed(w2_tbp[37:14]));

    // stage 3
    logic signed [27:0] w3_tc5;
    logic signed [25:0] w3_pa, w3_hx;
    logic signed [51:0] w3_aa;
    logic signed [41:0] w3_ap5, w3_ap2;
    logic signed [37:0] w3_h5x;
    logic signed [33:0] w3_hbp;
    logic signed [34:0] w3_hcp;
    logic signed [19:0] r_s3_tc;
    logic signed [24:0] r_s3_tfine;
    logic signed [51:0] r_s3_aa;
    logic signed [41:0] r_s3_ap5, r_s3_ap2;
    logic signed [37:0] r_s3_h5x;
    logic signed [23:0] r_s3_hb;
    logic signed [24:0] r_s3_hc;
    logic [19:0]        r_s3_raw_p;
    logic [15:0]        r_s3_raw_h;

    assign w3_tc5 = 28'(r_s2_tfine) * 28'sd5 + 28'sd128;
    assign w3_pa  = 26'(r_s2_tfine) - 26'sd128000;
    assign w3_hx  = 26'(r_s2_tfine) - 26'sd76800;
    assign w3_aa  = w3_pa * w3_pa;
    assign w3_ap5 = w3_pa * w_p5;
    assign w3_ap2 = w3_pa * w_p2;
    assign w3_h5x = w3_hx * w_h5;
    assign w3_hbp = w3_hx * w_h6;
    assign w3_hcp = w3_hx * w_h3;

    // stage 4
    logic signed [67:0] w4_aap6, w4_aap3;
    logic [63:0]        w4_ap5e, w4_p4e, w4_ap2e, w4_aap3s;
    logic signed [39:0] w4_hsum;
    logic signed [48:0] w4_bc;
    logic signed [19:0] r_s4_tc;
    logic signed [24:0] r_s4_tfine;
    logic [63:0]        r_s4_b;
    logic signed [63:0] r_s4_pa2;
    logic signed [24:0] r_s4_ha;
    logic signed [39:0] r_s4_he;
    logic [19:0]        r_s4_raw_p;

    assign w4_aap6  = r_s3_aa * w_p6;
    assign w4_aap3  = r_s3_aa * w_p3;
    assign w4_ap5e  = 64'(r_s3_ap5);
    assign w4_p4e   = 64'(w_p4);
    assign w4_ap2e  = 64'(r_s3_ap2);
    assign w4_aap3s = 64'($signed(w4_aap3[63:8]));
    assign w4_hsum  = $signed({10'b0, r_s3_raw_h, 14'b0}) - (40'(w_h4) <<< 20)
                    - 40'(r_s3_h5x) + 40'sd16384;
    assign w4_bc    = r_s3_hb * r_s3_hc;

    // stage 5
    logic signed [80:0] w5_pdp;
    logic signed [21:0] w5_praw;
    logic signed [56:0] w5_hfp;
    logic signed [19:0] r_s5_tc;
    logic signed [24:0] r_s5_tfine;
    logic signed [30:0] r_s5_pdiv;
    logic signed [63:0] r_s5_numpre;
    logic signed [24:0] r_s5_ha;
    logic signed [42:0] r_s5_hf;

    assign w5_pdp  = r_s4_pa2 * w_p1;
    assign w5_praw = 22'sd1048576 - $signed({2'b00, r_s4_raw_p});
    assign w5_hfp  = r_s4_he * w_h2 + 57'sd8192;

    // stage 6
    logic signed [76:0] w6_np;
    logic signed [67:0] w6_v;
    logic signed [19:0] r_s6_tc;
    logic signed [24:0] r_s6_tfine;
    logic signed [30:0] r_s6_pdiv;
    logic [63:0]        r_s6_pnum;
    logic signed [63:0] r_s6_v;

    assign w6_np = r_s5_numpre * 13'sd3125;
    assign w6_v  = r_s5_ha * r_s5_hf;

    // stage 7
    logic [63:0]        w7_w;
    logic [63:0]        w7_crp;
    logic signed [19:0] r_s7_tc;
    logic signed [24:0] r_s7_tfine;
    logic signed [30:0] r_s7_pdiv;
    logic [63:0]        r_s7_pnum;
    logic signed [63:0] r_s7_v;
    logic [63:0]        r_s7_ll;
    logic [31:0]        r_s7_cr;

    assign w7_w   = 64'($signed(r_s6_v[63:15]));
    assign w7_crp = w7_w[31:0] * w7_w[63:32];

    // stage 8
    logic signed [19:0] r_s8_tc;
    logic signed [24:0] r_s8_tfine;
    logic signed [30:0] r_s8_pdiv;
    logic [63:0]        r_s8_pnum;
    logic signed [63:0] r_s8_v;
    logic [63:0]        r_s8_sq;

    // stage 9
    logic signed [19:0] r_s9_tc;
    logic signed [24:0] r_s9_tfine;
    logic signed [30:0] r_s9_pdiv;
    logic [63:0]        r_s9_pnum;
    logic signed [63:0] r_s9_v;
    logic signed [56:0] r_s9_t7;

    // stage 10
    logic signed [65:0] w10_p;
    logic signed [19:0] r_s10_tc;
    logic signed [24:0] r_s10_tfine;
    logic signed [30:0] r_s10_pdiv;
    logic [63:0]        r_s10_pnum;
    logic signed [63:0] r_s10_v;
    logic signed [59:0] r_s10_th;

    assign w10_p = r_s9_t7 * w_h1;

    // stage 11: humidity clamp, divider operand setup
    logic signed [63:0] w11_vv;
    logic [28:0]        w11_vc;
    pthc_pkg::t_div_in  n_s11_div;
    pthc_pkg::t_div_in  r_s11_div;

    assign w11_vv = r_s10_v - 64'(r_s10_th);

    always_comb begin
        if (w11_vv < 0) begin
            w11_vc = '0;
        end else if (w11_vv > 64'(HUM_MAX_ACC)) begin
            w11_vc = HUM_MAX_ACC;
        end else begin
            w11_vc = w11_vv[28:0];
        end
        n_s11_div.num_mag     = r_s10_pnum[63] ? (64'd0 - r_s10_pnum) : r_s10_pnum;
        n_s11_div.den_mag     = r_s10_pdiv[30] ? (31'd0 - r_s10_pdiv) : r_s10_pdiv;
        n_s11_div.q_neg       = r_s10_pnum[63] ^ r_s10_pdiv[30];
        n_s11_div.side.tc     = r_s10_tc;
        n_s11_div.side.tfine  = r_s10_tfine;
        n_s11_div.side.hum    = w11_vc[28:12];
        n_s11_div.side.pvalid = (r_s10_pdiv != '0);
    end

    // front pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
        end else if (w_en) begin
            r_fvld <= {r_fvld[FRONT_STAGES-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_raw_t  <= i_s_axis_tdata[19:0];
            r_s0_raw_p  <= i_s_axis_tdata[39:20];
            r_s0_raw_h  <= i_s_axis_tdata[55:40];

            r_s1_ta     <= w1_tprod[33:11];
            r_s1_dd12   <= w1_dd[33:12];
            r_s1_raw_p  <= r_s0_raw_p;
            r_s1_raw_h  <= r_s0_raw_h;

            r_s2_tfine  <= n_s2_tfine;
            r_s2_raw_p  <= r_s1_raw_p;
            r_s2_raw_h  <= r_s1_raw_h;

            r_s3_tc     <= w3_tc5[27:8];
            r_s3_tfine  <= r_s2_tfine;
            r_s3_aa     <= w3_aa;
            r_s3_ap5    <= w3_ap5;
            r_s3_ap2    <= w3_ap2;
            r_s3_h5x    <= w3_h5x;
            r_s3_hb     <= w3_hbp[33:10];
            r_s3_hc     <= 25'($signed(w3_hcp[34:11])) + 25'sd32768;
            r_s3_raw_p  <= r_s2_raw_p;
            r_s3_raw_h  <= r_s2_raw_h;

            r_s4_tc     <= r_s3_tc;
            r_s4_tfine  <= r_s3_tfine;
            r_s4_b      <= w4_aap6[63:0] + (w4_ap5e << 17) + (w4_p4e << 35);
            r_s4_pa2    <= w4_aap3s + (w4_ap2e << 12) + 64'h0000_8000_0000_0000;
            r_s4_ha     <= w4_hsum[39:15];
            r_s4_he     <= 40'($signed(w4_bc[48:10])) + 40'sd2097152;
            r_s4_raw_p  <= r_s3_raw_p;

            r_s5_tc     <= r_s4_tc;
            r_s5_tfine  <= r_s4_tfine;
            r_s5_pdiv   <= w5_pdp[63:33];
            r_s5_numpre <= (64'(w5_praw) << 31) - r_s4_b;
            r_s5_ha     <= r_s4_ha;
            r_s5_hf     <= w5_hfp[56:14];

            r_s6_tc     <= r_s5_tc;
            r_s6_tfine  <= r_s5_tfine;
            r_s6_pdiv   <= r_s5_pdiv;
            r_s6_pnum   <= w6_np[63:0];
            r_s6_v      <= w6_v[63:0];

            r_s7_tc     <= r_s6_tc;
            r_s7_tfine  <= r_s6_tfine;
            r_s7_pdiv   <= r_s6_pdiv;
            r_s7_pnum   <= r_s6_pnum;
            r_s7_v      <= r_s6_v;
            r_s7_ll     <= w7_w[31:0] * w7_w[31:0];
            r_s7_cr     <= w7_crp[31:0];

            r_s8_tc     <= r_s7_tc;
            r_s8_tfine  <= r_s7_tfine;
            r_s8_pdiv   <= r_s7_pdiv;
            r_s8_pnum   <= r_s7_pnum;
            r_s8_v      <= r_s7_v;
            r_s8_sq     <= r_s7_ll + {r_s7_cr[30:0], 33'b0};

            r_s9_tc     <= r_s8_tc;
            r_s9_tfine  <= r_s8_tfine;
            r_s9_pdiv   <= r_s8_pdiv;
            r_s9_pnum   <= r_s8_pnum;
            r_s9_v      <= r_s8_v;
            r_s9_t7     <= r_s8_sq[63:7];

            r_s10_tc    <= r_s9_tc;
            r_s10_tfine <= r_s9_tfine;
            r_s10_pdiv  <= r_s9_pdiv;
            r_s10_pnum  <= r_s9_pnum;
            r_s10_v     <= r_s9_v;
            r_s10_th    <= w10_p[63:4];

            r_s11_div   <= n_s11_div;
        end
    end

    // pressure division
    logic               w_div_vld;
    pthc_pkg::t_div_out w_div_out;

    pthc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_fvld[FRONT_STAGES-1]),
        .i_data  (r_s11_div),
        .o_vld   (w_div_vld),
        .o_data  (w_div_out)
    );

    // back stages
    logic signed [66:0]  w2b_m1p;
    logic signed [79:0]  w2b_b8p;
    logic [63:0]         w3b_qe;
    logic [63:0]         w3b_c1p, w3b_c2p;
    logic [63:0]         w4b_prod;
    logic [31:0]         w4b_csum;

    logic signed [63:0]  r_b1_p;
    pthc_pkg::t_div_side r_b1_side;

    logic signed [63:0]  r_b2_p;
    logic signed [50:0]  r_b2_q13;
    logic [63:0]         r_b2_m1;
    logic signed [44:0]  r_b2_b8;
    pthc_pkg::t_div_side r_b2_side;

    logic signed [63:0]  r_b3_p;
    logic signed [44:0]  r_b3_b8;
    logic [63:0]         r_b3_ll;
    logic [31:0]         r_b3_c1, r_b3_c2;
    pthc_pkg::t_div_side r_b3_side;

    logic signed [63:0]  r_b4_p;
    logic signed [44:0]  r_b4_b8;
    logic signed [38:0]  r_b4_a;
    pthc_pkg::t_div_side r_b4_side;

    assign w2b_m1p  = $signed(r_b1_p[63:13]) * r_cal_p9;
    assign w2b_b8p  = r_b1_p * w_p8;
    assign w3b_qe   = 64'(r_b2_q13);
    assign w3b_c1p  = r_b2_m1[31:0] * w3b_qe[63:32];
    assign w3b_c2p  = r_b2_m1[63:32] * w3b_qe[31:0];
    assign w4b_csum = r_b3_c1 + r_b3_c2;
    assign w4b_prod = r_b3_ll + {w4b_csum, 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
        end else if (w_en) begin
            r_bvld <= {r_bvld[BACK_STAGES-2:0], w_div_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_p    <= w_div_out.q_neg ? $signed(64'd0 - w_div_out.quot_mag)
                                         : $signed(w_div_out.quot_mag);
            r_b1_side <= w_div_out.side;

            r_b2_p    <= r_b1_p;
            r_b2_q13  <= r_b1_p[63:13];
            r_b2_m1   <= w2b_m1p[63:0];
            r_b2_b8   <= w2b_b8p[63:19];
            r_b2_side <= r_b1_side;

            r_b3_p    <= r_b2_p;
            r_b3_b8   <= r_b2_b8;
            r_b3_ll   <= r_b2_m1[31:0] * w3b_qe[31:0];
            r_b3_c1   <= w3b_c1p[31:0];
            r_b3_c2   <= w3b_c2p[31:0];
            r_b3_side <= r_b2_side;

            r_b4_p    <= r_b3_p;
            r_b4_b8   <= r_b3_b8;
            r_b4_a    <= w4b_prod[63:25];
            r_b4_side <= r_b3_side;
        end
    end

    // final pressure sum and result assembly
    logic [63:0] w5b_sum;
    logic [31:0] w5b_press;
    logic        w_new_vld;
    t_result     w_new;
    t_result     r_out;
    t_result     r_skid;

    assign w5b_sum   = r_b4_p + 64'(r_b4_a) + 64'(r_b4_b8);
    assign w5b_press = w5b_sum[39:8] + {{12{w_p7[15]}}, w_p7, 4'b0};

    assign w_new_vld    = w_en & r_bvld[BACK_STAGES-1];
    assign w_new.tc     = 32'(r_b4_side.tc);
    assign w_new.tfine  = 32'(r_b4_side.tfine);
    assign w_new.press  = r_b4_side.pvalid ? w5b_press : 32'd0;
    assign w_new.pvalid = r_b4_side.pvalid;
    assign w_new.hum    = r_b4_side.hum;

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out      <= w_new;
                r_out_vld  <= w_new_vld;
            end
        end else if (w_new_vld) begin
            r_skid     <= w_new;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'b0, r_out.hum, r_out.press, r_out.tfine, r_out.tc};
    assign o_m_axis_tuser  = r_out.pvalid;

endmodule

[sim/pth_sensor_compensation_tb.sv]
// testbench for the pth sensor compensation datapath with a self-checking scoreboard
`timescale 1ns / 1ps

module pth_sensor_compensation_tb;

    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] press_q8;
        logic        press_valid;
        logic [16:0] hum_q10;
    } t_comp_result;

    class comp_scoreboard;
        logic [47:0]  cal_temp;
        logic [63:0]  cal_press_a;
        logic [63:0]  cal_press_b;
        logic [15:0]  cal_press_nine;
        logic [63:0]  cal_hum;
        t_comp_result expected_q[$];
        int unsigned  errors;

        function new();
            cal_temp = '0;
            cal_press_a = '0;
            cal_press_b = '0;
            cal_press_nine = '0;
            cal_hum = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_cal(logic [2:0] idx, logic [63:0] data);
            case (idx)
                pthc_pkg::CFG_CAL_TEMP:       cal_temp = data[47:0];
                pthc_pkg::CFG_CAL_PRESS_A:    cal_press_a = data;
                pthc_pkg::CFG_CAL_PRESS_B:    cal_press_b = data;
                pthc_pkg::CFG_CAL_PRESS_NINE: cal_press_nine = data[15:0];
                pthc_pkg::CFG_CAL_HUM:        cal_hum = data;
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // compensates one raw sample with the current calibration
        function void note_sample(logic [19:0] raw_t, logic [19:0] raw_p, logic [15:0] raw_h);
            longint adc_t, adc_p, adc_h;
            longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            longint h1, h2, h3, h4, h5, h6;
            longint a, b, c, d, e, f, p, x, v, tfine, tc;
            t_comp_result r;
            adc_t = longint'(raw_t);
            adc_p = longint'(raw_p);
            adc_h = longint'(raw_h);
            t1 = longint'(cal_temp[15:0]);
            t2 = longint'($signed(cal_temp[31:16]));
            t3 = longint'($signed(cal_temp[47:32]));
            p1 = longint'(cal_press_a[15:0]);
            p2 = longint'($signed(cal_press_a[31:16]));
            p3 = longint'($signed(cal_press_a[47:32]));
            p4 = longint'($signed(cal_press_a[63:48]));
            p5 = longint'($signed(cal_press_b[15:0]));
            p6 = longint'($signed(cal_press_b[31:16]));
            p7 = longint'($signed(cal_press_b[47:32]));
            p8 = longint'($signed(cal_press_b[63:48]));
            p9 = longint'($signed(cal_press_nine));
            h1 = longint'(cal_hum[7:0]);
            h2 = longint'($signed(cal_hum[23:8]));
            h3 = longint'(cal_hum[31:24]);
            h4 = longint'($signed(cal_hum[43:32]));
            h5 = longint'($signed(cal_hum[55:44]));
            h6 = longint'($signed(cal_hum[63:56]));

            a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
            d = (adc_t >>> 4) - t1;
            b = (((d * d) >>> 12) * t3) >>> 14;
            tfine = a + b;
            tc = (tfine * 5 + 128) >>> 8;

            a = tfine - 128000;
            b = a * a * p6;
            b = b + ((a * p5) <<< 17);
            b = b + (p4 <<< 35);
            a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
            a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
            if (a == 0) begin
                r.press_valid = 1'b0;
                r.press_q8 = '0;
            end else begin
                r.press_valid = 1'b1;
                p = 1048576 - adc_p;
                p = ((p <<< 31) - b) * 3125;
                p = (a == -1) ? -p : p / a;
                a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                b = (p8 * p) >>> 19;
                p = ((p + a + b) >>> 8) + (p7 <<< 4);
                r.press_q8 = p[31:0];
            end

            x = tfine - 76800;
            a = ((adc_h <<< 14) - (h4 <<< 20) - (h5 * x) + 16384) >>> 15;
            b = (x * h6) >>> 10;
            c = ((x * h3) >>> 11) + 32768;
            e = ((b * c) >>> 10) + 2097152;
            f = (e * h2 + 8192) >>> 14;
            v = a * f;
            v = v - (((((v >>> 15) * (v >>> 15)) >>> 7) * h1) >>> 4);
            if (v < 0) v = 0;
            if (v > 419430400) v = 419430400;

            r.temp_centi = tc[31:0];
            r.fine_temp = tfine[31:0];
            r.hum_q10 = v[28:12];
            expected_q.push_back(r);
        endfunction

        task check_result(logic [119:0] tdata, logic tuser);
            t_comp_result r;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(tdata), '0);
                return;
            end
            r = expected_q.pop_front();
            if (tdata[31:0] !== r.temp_centi)
                report_mismatch("temp_centi", 64'(tdata[31:0]), 64'(r.temp_centi));
            if (tdata[63:32] !== r.fine_temp)
                report_mismatch("fine_temp", 64'(tdata[63:32]), 64'(r.fine_temp));
            if (tdata[95:64] !== r.press_q8)
                report_mismatch("press_q8", 64'(tdata[95:64]), 64'(r.press_q8));
            if (tdata[112:96] !== r.hum_q10)
                report_mismatch("hum_q10", 64'(tdata[112:96]), 64'(r.hum_q10));
            if (tdata[119:113] !== '0)
                report_mismatch("tdata pad", 64'(tdata[119:113]), '0);
            if (tuser !== r.press_valid)
                report_mismatch("press_valid", 64'(tuser), 64'(r.press_valid));
        endtask
    endclass

    localparam logic [47:0] TYP_TEMP    = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PRESS_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PRESS_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] TYP_PRESS_9 = 16'd6000;
    localparam logic [63:0] TYP_HUM     = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index;
    logic [63:0]   i_cfg_data;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [55:0]   i_s_axis_tdata;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic [119:0]  o_m_axis_tdata;
    logic          o_m_axis_tuser;

    comp_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    pth_sensor_compensation i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver side, random stalls plus one long hold on request
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    task automatic send_sample(input logic [19:0] raw_t, input logic [19:0] raw_p,
                               input logic [15:0] raw_h);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {raw_h, raw_p, raw_t};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(raw_t, raw_p, raw_h);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_cal(idx, data);
    endtask

    task automatic load_cal(input logic [47:0] ct, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [15:0] p9,
                            input logic [63:0] ch);
        drain();
        write_reg(pthc_pkg::CFG_CAL_TEMP, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | ct);
        write_reg(pthc_pkg::CFG_CAL_PRESS_A, pa);
        write_reg(pthc_pkg::CFG_CAL_PRESS_B, pb);
        write_reg(pthc_pkg::CFG_CAL_PRESS_NINE, {$urandom, $urandom} & ~64'hFFFF | p9);
        write_reg(pthc_pkg::CFG_CAL_HUM, ch);
        // indexes past the register list must be ignored
        write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_corners();
        logic [19:0] t_set[3];
        logic [19:0] p_set[3];
        logic [15:0] h_set[3];
        t_set = '{20'd0, 20'hFFFFF, 20'd519888};
        p_set = '{20'd0, 20'hFFFFF, 20'd415148};
        h_set = '{16'd0, 16'hFFFF, 16'd30000};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                send_sample(t_set[i], p_set[j], h_set[(i + j) % 3]);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero calibration: pressure divisor is zero
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        load_cal(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_PRESS_9, TYP_HUM);
        send_corners();
        load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                 {4{16'h7FFF}}, 16'h7FFF, {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'd519888, 20'd415148, 16'd30000);
        load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                 {4{16'h8000}}, 16'h8000, {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'd519888, 20'd415148, 16'd30000);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph % 2 == 0)
                load_cal(TYP_TEMP ^ 48'($urandom & 32'h003F_003F),
                         TYP_PRESS_A ^ {$urandom, $urandom} & 64'h003F_003F_003F_003F,
                         TYP_PRESS_B ^ {$urandom, $urandom} & 64'h003F_003F_003F_003F,
                         TYP_PRESS_9 ^ 16'($urandom_range(0, 63)),
                         TYP_HUM ^ {$urandom, $urandom} & 64'h0F03_F03F_000F_0F0F);
            else
                load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         16'($urandom), {$urandom, $urandom});
            if (ph == 4)
                idle_on = 1'b0;
            if (ph == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < 105; n++) begin
                if (ph == 2 && n == 50)
                    drain();
                if ($urandom_range(0, 3) == 0)
                    send_sample(20'($urandom), 20'($urandom), 16'($urandom));
                else
                    send_sample(20'($urandom_range(400000, 600000)),
                                20'($urandom_range(250000, 500000)),
                                16'($urandom_range(15000, 45000)));
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
